[hw/rtl/ebl_pkg.sv]
// Energy budget ledger package: sizes, codes and slot helpers.
// Used by ebl_div, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ebl_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int DATA_W    = 32;
  localparam int E_W       = 31;
  localparam int WIDE_W    = 40;
  localparam int PADDR_W   = 3;

  localparam logic [2:0] FN_INIT   = 3'd0;
  localparam logic [2:0] FN_COUNT  = 3'd1;
  localparam logic [2:0] FN_CLOSE  = 3'd2;
  localparam logic [2:0] FN_REPORT = 3'd3;
  localparam logic [2:0] FN_QUERY  = 3'd4;
  localparam logic [2:0] FN_RESET  = 3'd5;

  localparam logic [3:0] UNIT_CTRL     = 4'd8;
  localparam logic [3:0] UNIT_LINUX    = 4'd9;
  localparam logic [3:0] UNIT_RPT_CTRL = 4'd3;
  localparam logic [3:0] SLOT_SKIP_A   = 4'd3;
  localparam logic [3:0] SLOT_SKIP_B   = 4'd4;

  localparam logic       REG_CAPACITY = 1'b0;
  localparam logic [E_W-1:0] CAP_RESET = 31'd99900000;

  // floor(x/5) = (x * RECIP5) >> 34, floor(x/6) = (x * RECIP3) >> 34, x < 2^32
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  function automatic logic slot_in_use(input logic [3:0] u);
    return ({1'b0, u} < 5'(NUM_SLOTS)) && (u != SLOT_SKIP_A) && (u != SLOT_SKIP_B) &&
           (u != UNIT_CTRL) && (u != UNIT_LINUX);
  endfunction

  function automatic logic [NUM_SLOTS-1:0] in_use_mask();
    logic [NUM_SLOTS-1:0] m;
    for (int i = 0; i < NUM_SLOTS; i++) m[i] = slot_in_use(4'(i));
    return m;
  endfunction

  localparam logic [NUM_SLOTS-1:0] IN_USE = in_use_mask();

endpackage

`default_nettype wire

[hw/rtl/ebl_ram.sv]
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ebl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ebl_div.sv]
// Restoring divider, one quotient bit per cycle, for spill / open-slot count.
// Depends on ebl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebl_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [ebl_pkg::WIDE_W-1:0]    dividend,
  input  wire [ebl_pkg::CNT_W-1:0]     divisor,
  output logic                         done,
  output logic [ebl_pkg::WIDE_W-1:0]   quotient
);

  localparam int ITER_W = $clog2(ebl_pkg::WIDE_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [ITER_W-1:0]           iter_r;
  logic [ebl_pkg::WIDE_W-1:0]  quo_r;
  logic [ebl_pkg::CNT_W-1:0]   rem_r;
  logic [ebl_pkg::CNT_W-1:0]   dvs_r;

  logic [ebl_pkg::CNT_W:0]     rem_sh;
  logic                        ge;
  logic [ebl_pkg::CNT_W:0]     rem_nxt;
  logic [ebl_pkg::WIDE_W-1:0]  quo_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[ebl_pkg::WIDE_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    quo_nxt = {quo_r[ebl_pkg::WIDE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= ITER_W'(ebl_pkg::WIDE_W);
      end else if (busy_r) begin
        iter_r <= iter_r - ITER_W'(1);
        if (iter_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt[ebl_pkg::CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[hw/rtl/energy_budget_ledger.sv]
// Energy budget ledger top level: sequencer, slot budget RAMs, APB register.
// Depends on ebl_pkg, ebl_ram and ebl_div.
//
// One item is worked at a time and in_ready is high only while the sequencer
// is idle; the result sits in an output register, so the next item can be taken
// while it waits. A closing interval with a surplus may run water-fill rounds,
// each a sweep of the slots followed, while any slot stays open, by a division
// of the spill over the open slots in the shared divider. Slot state clears at
// reset through per-entry valid bits, with no sweep.
`timescale 1ns / 1ps
`default_nettype none

module energy_budget_ledger (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [2:0]                         in_func,
  input  wire [3:0]                         in_unit,
  input  wire [ebl_pkg::E_W-1:0]            in_energy,
  input  wire [2:0]                         in_source_slot,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [31:0]                out_remaining,
  output logic signed [31:0]                out_used,
  output logic signed [31:0]                out_battery_drop,
  output logic                              out_status,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [ebl_pkg::PADDR_W-1:0]        paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int SW = ebl_pkg::SLOT_W;
  localparam int WW = ebl_pkg::WIDE_W;
  localparam int CW = ebl_pkg::CNT_W;
  localparam logic [SW-1:0] LAST = SW'(ebl_pkg::NUM_SLOTS - 1);

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DISP    = 18'h00002,
    S_RD      = 18'h00004,
    S_MOD     = 18'h00008,
    S_SRD     = 18'h00010,
    S_SMOD    = 18'h00020,
    S_FRD     = 18'h00040,
    S_FMOD    = 18'h00080,
    S_INIT_Q  = 18'h00100,
    S_INIT_SW = 18'h00200,
    S_CL_D    = 18'h00400,
    S_CL_K    = 18'h00800,
    S_CL_6    = 18'h01000,
    S_W_RD    = 18'h02000,
    S_W_MOD   = 18'h04000,
    S_W_END   = 18'h08000,
    S_W_DIV   = 18'h10000,
    S_DONE    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]               func_r, func_nxt;
  logic [3:0]               unit_r, unit_nxt;
  logic [ebl_pkg::E_W-1:0]  e_r, e_nxt;
  logic [2:0]               src_r, src_nxt;
  logic [SW-1:0]            addr_r, addr_nxt;
  logic [SW-1:0]            idx_r, idx_nxt;

  logic [31:0] cb_r, cb_nxt;
  logic [31:0] ctot_r, ctot_nxt;
  logic [31:0] ltot_r, ltot_nxt;
  logic [31:0] lastb_r, lastb_nxt;
  logic [31:0] isum_r, isum_nxt;
  logic [31:0] drop_r, drop_nxt;
  logic [31:0] mcap_r, mcap_nxt;
  logic [ebl_pkg::E_W-1:0] cap_r;

  logic [WW-1:0] cbw_r, cbw_nxt;
  logic [WW-1:0] share_r, share_nxt;
  logic [WW-1:0] spill_r, spill_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [ebl_pkg::NUM_SLOTS-1:0] open_r, open_nxt;

  logic [31:0] res_rem_r, res_rem_nxt;
  logic [31:0] res_used_r, res_used_nxt;
  logic [31:0] res_bu_r, res_bu_nxt;
  logic        res_st_r, res_st_nxt;

  logic        out_valid_r;
  logic [31:0] out_rem_r, out_used_r, out_bu_r;
  logic        out_st_r;

  logic [31:0] mult_a, mult_b;
  logic [63:0] prod_r;
  logic [31:0] x_r;
  logic [29:0] q5;
  logic [31:0] r5_full;
  logic        r_hi;
  logic [31:0] tenth, twofifth;

  logic        rem_we, used_we;
  logic [31:0] rem_wd, used_wd;
  logic [31:0] rem_q, used_q, rem_rd, used_rd;
  logic        rem_rv_r, used_rv_r;
  logic [ebl_pkg::NUM_SLOTS-1:0] rem_vld_r, used_vld_r;

  logic          div_start, div_done;
  logic [WW-1:0] div_q;

  logic          do_round, do_finish;
  logic [31:0]   e32, drop_c, ovf32;
  logic          u_ctl, u_ok, cons_ok;
  logic [WW-1:0] rwide, ovf_w, sh6;
  logic          cfg_wr;

  ebl_ram #(.WIDTH(32), .DEPTH(ebl_pkg::NUM_SLOTS)) u_rem_ram (
    .clk(clk), .we(rem_we), .waddr(addr_r), .wdata(rem_wd), .raddr(addr_r), .rdata(rem_q)
  );

  ebl_ram #(.WIDTH(32), .DEPTH(ebl_pkg::NUM_SLOTS)) u_used_ram (
    .clk(clk), .we(used_we), .waddr(addr_r), .wdata(used_wd), .raddr(addr_r), .rdata(used_q)
  );

  ebl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(spill_r), .divisor(cnt_r),
    .done(div_done), .quotient(div_q)
  );

  assign rem_rd  = rem_rv_r ? rem_q : '0;
  assign used_rd = used_rv_r ? used_q : '0;

  // reciprocal divide by 5 on the registered product
  always_comb begin
    q5       = prod_r[63:34];
    r5_full  = x_r - ({q5, 2'b00} + {2'b00, q5});
    r_hi     = r5_full[2:0] >= 3'd3;
    tenth    = {3'b000, q5[29:1]};
    twofifth = {1'b0, q5, 1'b0} + {31'd0, r_hi};
  end

  always_comb begin
    e32     = {1'b0, e_r};
    u_ctl   = (unit_r == ebl_pkg::UNIT_CTRL) || (unit_r == ebl_pkg::UNIT_LINUX);
    u_ok    = u_ctl || ebl_pkg::slot_in_use(unit_r);
    cons_ok = (unit_r == ebl_pkg::UNIT_RPT_CTRL) || ebl_pkg::slot_in_use(unit_r);
    drop_c  = lastb_r - e32;
    ovf_w   = cbw_r - {8'd0, twofifth};
    ovf32   = ovf_w[31:0];
    sh6     = {10'd0, prod_r[63:34]};
    rwide   = {{8{rem_rd[31]}}, rem_rd} + share_r;
  end

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r; unit_nxt = unit_r; e_nxt = e_r; src_nxt = src_r;
    addr_nxt = addr_r; idx_nxt = idx_r;
    cb_nxt = cb_r; ctot_nxt = ctot_r; ltot_nxt = ltot_r; lastb_nxt = lastb_r;
    isum_nxt = isum_r; drop_nxt = drop_r; mcap_nxt = mcap_r;
    cbw_nxt = cbw_r; share_nxt = share_r; spill_nxt = spill_r; cnt_nxt = cnt_r;
    open_nxt = open_r;
    res_rem_nxt = res_rem_r; res_used_nxt = res_used_r;
    res_bu_nxt = res_bu_r; res_st_nxt = res_st_r;
    mult_a = e32;
    mult_b = ebl_pkg::RECIP5;
    rem_we = 1'b0; used_we = 1'b0;
    rem_wd = rem_rd; used_wd = used_rd;
    div_start = 1'b0;
    do_round = 1'b0; do_finish = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = in_func; unit_nxt = in_unit;
          e_nxt = in_energy; src_nxt = in_source_slot;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_bu_nxt = '0;
        res_st_nxt = 1'b0;
        unique case (func_r)
          ebl_pkg::FN_INIT: begin
            state_nxt = S_INIT_Q;
          end
          ebl_pkg::FN_COUNT: begin
            if (!u_ok) begin
              res_st_nxt = 1'b1; res_rem_nxt = '0; res_used_nxt = '0;
              state_nxt = S_DONE;
            end else if (u_ctl) begin
              cb_nxt = cb_r - e32;
              isum_nxt = isum_r + e32;
              res_rem_nxt = cb_r - e32;
              if (unit_r == ebl_pkg::UNIT_CTRL) begin
                ctot_nxt = ctot_r + e32;
                res_used_nxt = ctot_r + e32;
              end else begin
                ltot_nxt = ltot_r + e32;
                res_used_nxt = ltot_r + e32;
              end
              state_nxt = S_DONE;
            end else begin
              addr_nxt = SW'(unit_r);
              state_nxt = S_RD;
            end
          end
          ebl_pkg::FN_CLOSE: begin
            drop_nxt = drop_c;
            lastb_nxt = e32;
            open_nxt = ebl_pkg::IN_USE;
            if ($signed(drop_c) >= $signed(isum_r)) begin
              cb_nxt = cb_r - drop_c + isum_r;
              isum_nxt = '0;
              res_rem_nxt = cb_r - drop_c + isum_r;
              res_used_nxt = ctot_r;
              res_bu_nxt = drop_c;
              state_nxt = S_DONE;
            end else begin
              mult_a = isum_r - drop_c;
              cbw_nxt = {{8{cb_r[31]}}, cb_r};
              state_nxt = S_CL_D;
            end
          end
          ebl_pkg::FN_REPORT: begin
            if (!(cons_ok && ebl_pkg::slot_in_use({1'b0, src_r}))) begin
              res_st_nxt = 1'b1; res_rem_nxt = '0; res_used_nxt = '0;
              state_nxt = S_DONE;
            end else if (unit_r == ebl_pkg::UNIT_RPT_CTRL) begin
              cb_nxt = cb_r - e32;
              ctot_nxt = ctot_r + e32;
              addr_nxt = SW'(src_r);
              state_nxt = S_SRD;
            end else begin
              addr_nxt = SW'(unit_r);
              state_nxt = S_RD;
            end
          end
          ebl_pkg::FN_QUERY, ebl_pkg::FN_RESET: begin
            if (!u_ok) begin
              res_st_nxt = 1'b1; res_rem_nxt = '0; res_used_nxt = '0;
              state_nxt = S_DONE;
            end else if (u_ctl) begin
              res_rem_nxt = cb_r;
              if (func_r == ebl_pkg::FN_RESET) begin
                res_used_nxt = '0;
                if (unit_r == ebl_pkg::UNIT_CTRL) ctot_nxt = '0;
                else ltot_nxt = '0;
              end else begin
                res_used_nxt = (unit_r == ebl_pkg::UNIT_CTRL) ? ctot_r : ltot_r;
              end
              state_nxt = S_DONE;
            end else begin
              addr_nxt = SW'(unit_r);
              state_nxt = S_RD;
            end
          end
          default: begin
            res_st_nxt = 1'b1; res_rem_nxt = '0; res_used_nxt = '0;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RD: state_nxt = S_MOD;
      S_MOD: begin
        unique case (func_r)
          ebl_pkg::FN_COUNT: begin
            rem_we = 1'b1; used_we = 1'b1;
            rem_wd = rem_rd - e32; used_wd = used_rd + e32;
            isum_nxt = isum_r + e32;
            res_rem_nxt = rem_rd - e32; res_used_nxt = used_rd + e32;
            state_nxt = S_DONE;
          end
          ebl_pkg::FN_REPORT: begin
            rem_we = 1'b1; used_we = 1'b1;
            rem_wd = rem_rd - e32; used_wd = used_rd + e32;
            addr_nxt = SW'(src_r);
            state_nxt = S_SRD;
          end
          ebl_pkg::FN_RESET: begin
            used_we = 1'b1; used_wd = '0;
            res_rem_nxt = rem_rd; res_used_nxt = '0;
            state_nxt = S_DONE;
          end
          default: begin
            res_rem_nxt = rem_rd; res_used_nxt = used_rd;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SRD: state_nxt = S_SMOD;
      S_SMOD: begin
        rem_we = 1'b1; used_we = 1'b1;
        rem_wd = rem_rd + e32; used_wd = used_rd - e32;
        if (unit_r == ebl_pkg::UNIT_RPT_CTRL) begin
          res_rem_nxt = cb_r; res_used_nxt = ctot_r;
          state_nxt = S_DONE;
        end else begin
          addr_nxt = SW'(unit_r);
          state_nxt = S_FRD;
        end
      end
      S_FRD: state_nxt = S_FMOD;
      S_FMOD: begin
        res_rem_nxt = rem_rd; res_used_nxt = used_rd;
        state_nxt = S_DONE;
      end
      S_INIT_Q: begin
        cb_nxt = twofifth;
        ctot_nxt = '0; ltot_nxt = '0; isum_nxt = '0;
        lastb_nxt = e32;
        mcap_nxt = tenth;
        idx_nxt = '0; addr_nxt = '0;
        state_nxt = S_INIT_SW;
      end
      S_INIT_SW: begin
        rem_we = ebl_pkg::IN_USE[idx_r];
        rem_wd = mcap_r;
        used_we = 1'b1; used_wd = '0;
        if (idx_r == LAST) begin
          res_rem_nxt = cb_r; res_used_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + SW'(1); addr_nxt = addr_r + SW'(1);
        end
      end
      S_CL_D: begin
        share_nxt = {8'd0, tenth};
        cbw_nxt = cbw_r + {8'd0, twofifth};
        mult_a = {1'b0, cap_r};
        state_nxt = S_CL_K;
      end
      S_CL_K: begin
        mcap_nxt = tenth;
        if ($signed(cbw_r) > $signed({8'd0, twofifth})) begin
          mult_a = ovf32;
          mult_b = ebl_pkg::RECIP3;
          cbw_nxt = {8'd0, twofifth};
          state_nxt = S_CL_6;
        end else if (share_r != '0) begin
          do_round = 1'b1;
        end else begin
          do_finish = 1'b1;
        end
      end
      S_CL_6: begin
        share_nxt = share_r + sh6;
        if ((share_r + sh6) != '0) do_round = 1'b1;
        else do_finish = 1'b1;
      end
      S_W_RD: begin
        if (open_r[idx_r]) begin
          state_nxt = S_W_MOD;
        end else if (idx_r == LAST) begin
          state_nxt = S_W_END;
        end else begin
          idx_nxt = idx_r + SW'(1); addr_nxt = addr_r + SW'(1);
        end
      end
      S_W_MOD: begin
        rem_we = 1'b1;
        if ($signed(rwide) > $signed({8'd0, mcap_r})) begin
          spill_nxt = spill_r + (rwide - {8'd0, mcap_r});
          rem_wd = mcap_r;
          open_nxt[idx_r] = 1'b0;
        end else begin
          rem_wd = rwide[31:0];
          cnt_nxt = cnt_r + CW'(1);
        end
        if (idx_r == LAST) begin
          state_nxt = S_W_END;
        end else begin
          idx_nxt = idx_r + SW'(1); addr_nxt = addr_r + SW'(1);
          state_nxt = S_W_RD;
        end
      end
      S_W_END: begin
        if (cnt_r == '0) begin
          cbw_nxt = cbw_r + spill_r;
          do_finish = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = S_W_DIV;
        end
      end
      S_W_DIV: begin
        if (div_done) begin
          share_nxt = div_q;
          if (div_q != '0) do_round = 1'b1;
          else do_finish = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_round) begin
      idx_nxt = '0; addr_nxt = '0; spill_nxt = '0; cnt_nxt = '0;
      state_nxt = S_W_RD;
    end
    if (do_finish) begin
      cb_nxt = cbw_nxt[31:0];
      isum_nxt = '0;
      res_rem_nxt = cbw_nxt[31:0];
      res_used_nxt = ctot_r;
      res_bu_nxt = drop_r;
      state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cb_r <= '0; ctot_r <= '0; ltot_r <= '0; lastb_r <= '0; isum_r <= '0;
      rem_vld_r <= '0; used_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cb_r <= cb_nxt; ctot_r <= ctot_nxt; ltot_r <= ltot_nxt;
      lastb_r <= lastb_nxt; isum_r <= isum_nxt;
      if (rem_we) rem_vld_r[addr_r] <= 1'b1;
      if (used_we) used_vld_r[addr_r] <= 1'b1;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= ebl_pkg::CAP_RESET;
    else if (cfg_wr && paddr[2] == ebl_pkg::REG_CAPACITY) cap_r <= pwdata[30:0];
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; unit_r <= unit_nxt; e_r <= e_nxt; src_r <= src_nxt;
    addr_r <= addr_nxt; idx_r <= idx_nxt;
    drop_r <= drop_nxt; mcap_r <= mcap_nxt;
    cbw_r <= cbw_nxt; share_r <= share_nxt; spill_r <= spill_nxt; cnt_r <= cnt_nxt;
    open_r <= open_nxt;
    res_rem_r <= res_rem_nxt; res_used_r <= res_used_nxt;
    res_bu_r <= res_bu_nxt; res_st_r <= res_st_nxt;
    prod_r <= mult_a * mult_b;
    x_r <= mult_a;
    rem_rv_r <= rem_vld_r[addr_r];
    used_rv_r <= used_vld_r[addr_r];
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_rem_r <= res_rem_r; out_used_r <= res_used_r;
      out_bu_r <= res_bu_r; out_st_r <= res_st_r;
    end
  end

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ebl_pkg::REG_CAPACITY) ? {1'b0, cap_r} : '0;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_remaining    = out_rem_r;
  assign out_used         = out_used_r;
  assign out_battery_drop = out_bu_r;
  assign out_status       = out_st_r;

endmodule

`default_nettype wire

[hw/rtl/ebl_checker.sv]
// Port-level checks for the energy budget ledger, bound to the top level.
// Depends on ebl_pkg and energy_budget_ledger.
`timescale 1ns / 1ps
`default_nettype none

module ebl_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire signed [31:0]          out_remaining,
  input wire signed [31:0]          out_used,
  input wire signed [31:0]          out_battery_drop,
  input wire                        out_status,
  input wire                        psel,
  input wire                        penable,
  input wire                        pwrite,
  input wire [ebl_pkg::PADDR_W-1:0] paddr,
  input wire [31:0]                 pwdata,
  input wire [31:0]                 prdata,
  input wire                        pready
);

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an input beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_remaining) && $stable(out_used) &&
                                   $stable(out_battery_drop) && $stable(out_status)))
    else $error("stalled result changed");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_remaining == 0 && out_used == 0 && out_battery_drop == 0))
    else $error("ignored item carries nonzero fields");

  a_cap_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr == 3'd0) |=>
      (paddr != 3'd0 || prdata == {1'b0, $past(pwdata[30:0])}))
    else $error("capacity readback mismatch");

endmodule

bind energy_budget_ledger ebl_checker u_ebl_checker (.*);

`default_nettype wire
